FILE: design/pfn_pkg.sv
// Package for the phase-field node update pipeline.
// Holds the fixed-point widths, limits and the clamp functions.
// No dependencies.
package pfn_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int INT_W         = 39;
    localparam int CALC_W        = 64;
    localparam int PHI_WIDTH_DEF = 18;
    localparam int CFG_W         = 24;
    localparam int STEP_W        = 24;
    localparam int INV_W         = 24;
    localparam int DF_W          = 21;
    localparam int ENERGY_W      = 32;

    localparam logic signed [CALC_W-1:0] LIM  = 64'sd274877906943;
    localparam logic signed [CALC_W-1:0] ONE  = 64'sd65536;
    localparam logic signed [CALC_W-1:0] EMAX = 64'sd2147483647;
    localparam logic signed [CALC_W-1:0] EMIN = -64'sd2147483648;

    function automatic logic signed [INT_W-1:0] sat_lim(input logic signed [CALC_W-1:0] x);
        logic signed [INT_W-1:0] r;
        if (x > LIM) begin
            r = INT_W'(LIM);
        end else if (x < -LIM) begin
            r = INT_W'(-LIM);
        end else begin
            r = INT_W'(x);
        end
        return r;
    endfunction

    function automatic logic over_lim(input logic signed [CALC_W-1:0] x);
        return (x > LIM) || (x < -LIM);
    endfunction

endpackage

FILE: design/phase_field_node_update.sv
// Phase-field node update: explicit Euler step and local energy density.
// One node per cycle sustained while the skid register is empty; results leave via the output register.
// The datapath is a 12-stage pipeline with four rounds of pipelined Q16 multipliers.
// An output register and a skid register let two results wait before the input stalls.
// Reset (synchronous, aresetn low) clears all valid bits and loads the register defaults.
module phase_field_node_update #(
    parameter int PHI_WIDTH = pfn_pkg::PHI_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [1:0]                          cfg_addr,
    input  logic [pfn_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [PHI_WIDTH-1:0]         s_center_phi,
    input  logic signed [PHI_WIDTH-1:0]         s_east_phi,
    input  logic signed [PHI_WIDTH-1:0]         s_west_phi,
    input  logic signed [PHI_WIDTH-1:0]         s_north_phi,
    input  logic signed [PHI_WIDTH-1:0]         s_south_phi,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [PHI_WIDTH-1:0]         m_next_phi,
    output logic signed [pfn_pkg::ENERGY_W-1:0] m_energy_density,
    output logic                                m_saturated
);

    localparam int IW     = pfn_pkg::INT_W;
    localparam int CW     = pfn_pkg::CALC_W;
    localparam int PW     = PHI_WIDTH;
    localparam int EW     = pfn_pkg::ENERGY_W;
    localparam int PIPE_D = 12;
    localparam logic signed [CW-1:0] PMAX = (CW'(1) <<< (PW - 1)) - CW'(1);
    localparam logic signed [CW-1:0] PMIN = -PMAX - CW'(1);

    typedef enum logic [1:0] {
        CFG_STEP_SIZE      = 2'd0,
        CFG_INV_SPACING_SQ = 2'd1,
        CFG_DRIVING_FORCE  = 2'd2
    } cfg_addr_t;

    logic [pfn_pkg::STEP_W-1:0]       step_size_reg;
    logic [pfn_pkg::INV_W-1:0]        inv_spacing_sq_reg;
    logic signed [pfn_pkg::DF_W-1:0]  driving_force_reg;

    logic signed [IW-1:0] dt_op, inv_op, df_op;

    logic                 pipe_en;
    logic [PIPE_D-1:0]    valid_reg;

    logic signed [PW-1:0] phi_line_reg  [1:12];
    logic signed [IW-1:0] lap_line_reg  [4:9];
    logic signed [IW-1:0] tp_line_reg   [4:7];
    logic signed [IW-1:0] gpr_line_reg  [7:9];
    logic signed [IW-1:0] half_line_reg [7:12];
    logic signed [IW-1:0] gval_line_reg [7:12];
    logic                 sat_line_reg  [4:12];

    logic signed [IW-1:0] lapsum1_reg, omx1_reg, gx1_reg, gy1_reg;
    logic signed [IW-1:0] lapsum_next, omx_next, gx_next, gy_next;
    logic signed [IW-1:0] ph2_4_reg, om2_4_reg, ta4_reg, sq4_reg;
    logic signed [IW-1:0] g30_7_reg, ph3_7_reg, br10_reg, pval10_reg;

    logic signed [IW-1:0] lap_q, ph2_q, om2_q, gxx_q, gyy_q;
    logic                 lap_c, ph2_c, om2_c, gxx_c, gyy_c;
    logic signed [IW-1:0] gval_q, gq_q, ph3_q, grad_q;
    logic                 gval_c, gq_c, ph3_c, grad_c;
    logic signed [IW-1:0] drive_q, pval_q, step_q, dfp_q;
    logic                 drive_c, pval_c, step_c, dfp_c;

    logic signed [CW-1:0] ta_sum, tp_sum, sq_sum, gpr_sum, g30_sum, br_sum;
    logic signed [CW-1:0] nxt_sum, en_sum;
    logic                 sat4_next, sat7_next, sat10_next;
    logic                 nclip, eclip;

    logic signed [PW-1:0] fin_next_phi;
    logic signed [EW-1:0] fin_energy;
    logic                 fin_sat;

    logic                 m_valid_reg, skid_valid_reg;
    logic signed [PW-1:0] m_next_phi_reg, skid_next_phi_reg;
    logic signed [EW-1:0] m_energy_density_reg, skid_energy_density_reg;
    logic                 m_saturated_reg, skid_saturated_reg;
    logic                 load_from_pipe, load_from_skid, to_skid;

    assign dt_op  = IW'({1'b0, step_size_reg});
    assign inv_op = IW'({1'b0, inv_spacing_sq_reg});
    assign df_op  = IW'(driving_force_reg);

    assign pipe_en = !skid_valid_reg;
    assign s_ready = pipe_en;

    assign lapsum_next = IW'(CW'(s_east_phi) + CW'(s_west_phi) + CW'(s_north_phi)
                             + CW'(s_south_phi) - (CW'(s_center_phi) <<< 2));
    assign omx_next    = IW'(pfn_pkg::ONE - CW'(s_center_phi));
    assign gx_next     = IW'(CW'(s_east_phi) - CW'(s_west_phi));
    assign gy_next     = IW'(CW'(s_north_phi) - CW'(s_south_phi));

    pfn_qmul u_lap  (.aclk, .en(pipe_en), .a(lapsum1_reg), .b(inv_op), .p(lap_q), .clip(lap_c));
    pfn_qmul u_ph2  (.aclk, .en(pipe_en), .a(IW'(phi_line_reg[1])), .b(IW'(phi_line_reg[1])),
                     .p(ph2_q), .clip(ph2_c));
    pfn_qmul u_om2  (.aclk, .en(pipe_en), .a(omx1_reg), .b(omx1_reg), .p(om2_q), .clip(om2_c));
    pfn_qmul u_gxx  (.aclk, .en(pipe_en), .a(gx1_reg), .b(gx1_reg), .p(gxx_q), .clip(gxx_c));
    pfn_qmul u_gyy  (.aclk, .en(pipe_en), .a(gy1_reg), .b(gy1_reg), .p(gyy_q), .clip(gyy_c));

    assign ta_sum = (CW'(ph2_q) <<< 1) - 64'sd3 * CW'(phi_line_reg[3]) + pfn_pkg::ONE;
    assign tp_sum = 64'sd6 * CW'(ph2_q) - 64'sd15 * CW'(phi_line_reg[3])
                    + 64'sd10 * pfn_pkg::ONE;
    assign sq_sum = CW'(gxx_q) + CW'(gyy_q);
    assign sat4_next = lap_c | ph2_c | om2_c | gxx_c | gyy_c | pfn_pkg::over_lim(ta_sum)
                       | pfn_pkg::over_lim(tp_sum) | pfn_pkg::over_lim(sq_sum);

    pfn_qmul u_gval (.aclk, .en(pipe_en), .a(ph2_4_reg), .b(om2_4_reg), .p(gval_q),
                     .clip(gval_c));
    pfn_qmul u_gq   (.aclk, .en(pipe_en), .a(IW'(phi_line_reg[4])), .b(ta4_reg), .p(gq_q),
                     .clip(gq_c));
    pfn_qmul u_ph3  (.aclk, .en(pipe_en), .a(ph2_4_reg), .b(IW'(phi_line_reg[4])), .p(ph3_q),
                     .clip(ph3_c));
    pfn_qmul u_grad (.aclk, .en(pipe_en), .a(sq4_reg), .b(inv_op), .p(grad_q), .clip(grad_c));

    assign gpr_sum = CW'(gq_q) <<< 1;
    assign g30_sum = 64'sd30 * CW'(gval_q);
    assign sat7_next = sat_line_reg[6] | gval_c | gq_c | ph3_c | grad_c
                       | pfn_pkg::over_lim(gpr_sum) | pfn_pkg::over_lim(g30_sum);

    pfn_qmul u_drive (.aclk, .en(pipe_en), .a(df_op), .b(g30_7_reg), .p(drive_q),
                      .clip(drive_c));
    pfn_qmul u_pval  (.aclk, .en(pipe_en), .a(ph3_7_reg), .b(tp_line_reg[7]), .p(pval_q),
                      .clip(pval_c));

    assign br_sum = CW'(lap_line_reg[9]) - CW'(gpr_line_reg[9]) + CW'(drive_q);
    assign sat10_next = sat_line_reg[9] | drive_c | pval_c | pfn_pkg::over_lim(br_sum);

    pfn_qmul u_step (.aclk, .en(pipe_en), .a(dt_op), .b(br10_reg), .p(step_q), .clip(step_c));
    pfn_qmul u_dfp  (.aclk, .en(pipe_en), .a(df_op), .b(pval10_reg), .p(dfp_q), .clip(dfp_c));

    always_comb begin
        nxt_sum = CW'(phi_line_reg[12]) + CW'(step_q);
        en_sum  = CW'(half_line_reg[12]) + CW'(gval_line_reg[12]) - CW'(dfp_q);
        nclip   = (nxt_sum > PMAX) || (nxt_sum < PMIN);
        eclip   = (en_sum > pfn_pkg::EMAX) || (en_sum < pfn_pkg::EMIN);
        if (nxt_sum > PMAX) begin
            fin_next_phi = PW'(PMAX);
        end else if (nxt_sum < PMIN) begin
            fin_next_phi = PW'(PMIN);
        end else begin
            fin_next_phi = PW'(nxt_sum);
        end
        if (en_sum > pfn_pkg::EMAX) begin
            fin_energy = EW'(pfn_pkg::EMAX);
        end else if (en_sum < pfn_pkg::EMIN) begin
            fin_energy = EW'(pfn_pkg::EMIN);
        end else begin
            fin_energy = EW'(en_sum);
        end
        fin_sat = sat_line_reg[12] | step_c | dfp_c | nclip | eclip;
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            phi_line_reg[1] <= s_center_phi;
            for (int k = 2; k <= 12; k++) begin
                phi_line_reg[k] <= phi_line_reg[k-1];
            end
            lapsum1_reg <= lapsum_next;
            omx1_reg    <= omx_next;
            gx1_reg     <= gx_next;
            gy1_reg     <= gy_next;

            lap_line_reg[4] <= lap_q;
            for (int k = 5; k <= 9; k++) begin
                lap_line_reg[k] <= lap_line_reg[k-1];
            end
            tp_line_reg[4] <= pfn_pkg::sat_lim(tp_sum);
            for (int k = 5; k <= 7; k++) begin
                tp_line_reg[k] <= tp_line_reg[k-1];
            end
            ph2_4_reg <= ph2_q;
            om2_4_reg <= om2_q;
            ta4_reg   <= pfn_pkg::sat_lim(ta_sum);
            sq4_reg   <= pfn_pkg::sat_lim(sq_sum);

            sat_line_reg[4]  <= sat4_next;
            sat_line_reg[5]  <= sat_line_reg[4];
            sat_line_reg[6]  <= sat_line_reg[5];
            sat_line_reg[7]  <= sat7_next;
            sat_line_reg[8]  <= sat_line_reg[7];
            sat_line_reg[9]  <= sat_line_reg[8];
            sat_line_reg[10] <= sat10_next;
            sat_line_reg[11] <= sat_line_reg[10];
            sat_line_reg[12] <= sat_line_reg[11];

            gpr_line_reg[7] <= pfn_pkg::sat_lim(gpr_sum);
            for (int k = 8; k <= 9; k++) begin
                gpr_line_reg[k] <= gpr_line_reg[k-1];
            end
            half_line_reg[7] <= grad_q >>> 3;
            gval_line_reg[7] <= gval_q;
            for (int k = 8; k <= 12; k++) begin
                half_line_reg[k] <= half_line_reg[k-1];
                gval_line_reg[k] <= gval_line_reg[k-1];
            end
            g30_7_reg <= pfn_pkg::sat_lim(g30_sum);
            ph3_7_reg <= ph3_q;

            br10_reg   <= pfn_pkg::sat_lim(br_sum);
            pval10_reg <= pval_q;
        end
    end

    assign load_from_pipe = pipe_en && (!m_valid_reg || m_ready);
    assign load_from_skid = !pipe_en && m_ready;
    assign to_skid        = pipe_en && m_valid_reg && !m_ready && valid_reg[PIPE_D-1];

    always_ff @(posedge aclk) begin
        if (load_from_pipe) begin
            m_next_phi_reg       <= fin_next_phi;
            m_energy_density_reg <= fin_energy;
            m_saturated_reg      <= fin_sat;
        end else if (load_from_skid) begin
            m_next_phi_reg       <= skid_next_phi_reg;
            m_energy_density_reg <= skid_energy_density_reg;
            m_saturated_reg      <= skid_saturated_reg;
        end
        if (to_skid) begin
            skid_next_phi_reg       <= fin_next_phi;
            skid_energy_density_reg <= fin_energy;
            skid_saturated_reg      <= fin_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg          <= '0;
            m_valid_reg        <= 1'b0;
            skid_valid_reg     <= 1'b0;
            step_size_reg      <= pfn_pkg::STEP_W'(pfn_pkg::ONE);
            inv_spacing_sq_reg <= pfn_pkg::INV_W'(pfn_pkg::ONE);
            driving_force_reg  <= '0;
        end else begin
            if (pipe_en) begin
                valid_reg <= {valid_reg[PIPE_D-2:0], s_valid};
            end
            if (load_from_pipe) begin
                m_valid_reg <= valid_reg[PIPE_D-1];
            end
            if (to_skid) begin
                skid_valid_reg <= 1'b1;
            end else if (load_from_skid) begin
                skid_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                unique case (cfg_addr_t'(cfg_addr))
                    CFG_STEP_SIZE:      step_size_reg      <= cfg_wdata[pfn_pkg::STEP_W-1:0];
                    CFG_INV_SPACING_SQ: inv_spacing_sq_reg <= cfg_wdata[pfn_pkg::INV_W-1:0];
                    CFG_DRIVING_FORCE:  driving_force_reg  <= cfg_wdata[pfn_pkg::DF_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_next_phi       = m_next_phi_reg;
    assign m_energy_density = m_energy_density_reg;
    assign m_saturated      = m_saturated_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid holds a result while the output register is empty");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> valid_reg == $past(valid_reg))
        else $error("pipeline advanced during a stall");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (pipe_en && valid_reg[PIPE_D-1] && m_valid_reg && !m_ready) |=> skid_valid_reg)
        else $error("finished result dropped while output stalled");

endmodule

FILE: design/pfn_qmul.sv
// Two-stage Q16 fractional multiplier: floor(a*b / 2^16), clamped.
// One operand is split in two halves to keep each partial product narrow.
// Depends on pfn_pkg.
module pfn_qmul (
    input  logic                            aclk,
    input  logic                            en,
    input  logic signed [pfn_pkg::INT_W-1:0] a,
    input  logic signed [pfn_pkg::INT_W-1:0] b,
    output logic signed [pfn_pkg::INT_W-1:0] p,
    output logic                            clip
);

    localparam int IW = pfn_pkg::INT_W;
    localparam int CW = pfn_pkg::CALC_W;
    localparam int LW = IW / 2;
    localparam int HW = IW - LW;
    localparam int FW = 2 * IW;

    logic signed [HW-1:0]      a_hi;
    logic signed [LW:0]        a_lo;
    logic signed [HW+IW-1:0]   prod_hi_reg;
    logic signed [LW+IW:0]     prod_lo_reg;
    logic signed [FW-1:0]      full;
    logic signed [CW-1:0]      shifted;
    logic signed [IW-1:0]      p_reg;
    logic                      clip_reg;

    assign a_hi = a[IW-1:LW];
    assign a_lo = {1'b0, a[LW-1:0]};

    assign full    = (FW'(prod_hi_reg) <<< LW) + FW'(prod_lo_reg);
    assign shifted = CW'(full >>> pfn_pkg::FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_hi_reg <= a_hi * b;
            prod_lo_reg <= a_lo * b;
            p_reg       <= pfn_pkg::sat_lim(shifted);
            clip_reg    <= pfn_pkg::over_lim(shifted);
        end
    end

    assign p    = p_reg;
    assign clip = clip_reg;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for phase_field_node_update: node streams in, updates out.
// Predicts next_phi, energy density and the clip flag per node at the block's widths.
// Depends on pfn_pkg and the phase_field_node_update RTL.
module tb;

    localparam int PHI_W = pfn_pkg::PHI_WIDTH_DEF;
    localparam int FRAC_BITS = pfn_pkg::FRAC_BITS;
    localparam int ENERGY_W = pfn_pkg::ENERGY_W;
    localparam int CFG_W = pfn_pkg::CFG_W;
    localparam int DF_W = pfn_pkg::DF_W;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_EVERY = 300;
    localparam int HOLD_CYCLES = 64;
    localparam int NODES_PER_PHASE = 118;
    localparam int RAND_PHASES = 7;

    localparam logic [1:0] REG_STEP = 2'd0;
    localparam logic [1:0] REG_INV_SPACING = 2'd1;
    localparam logic [1:0] REG_DRIVE = 2'd2;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam longint FX_LIM = pfn_pkg::LIM;
    localparam longint FX_ONE = pfn_pkg::ONE;
    localparam longint PHI_MAX = (longint'(1) <<< (PHI_W - 1)) - 1;
    localparam longint PHI_MIN = -PHI_MAX - 1;
    localparam longint EN_MAX = pfn_pkg::EMAX;
    localparam longint EN_MIN = pfn_pkg::EMIN;

    typedef logic signed [PHI_W-1:0] phi_t;

    typedef struct {
        phi_t c;
        phi_t e;
        phi_t w;
        phi_t n;
        phi_t s;
    } node_t;

    typedef struct {
        phi_t                        next_phi;
        logic signed [ENERGY_W-1:0]  energy;
        logic                        sat;
    } update_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_addr = REG_STEP;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    phi_t s_center_phi = '0;
    phi_t s_east_phi = '0;
    phi_t s_west_phi = '0;
    phi_t s_north_phi = '0;
    phi_t s_south_phi = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    phi_t m_next_phi;
    logic signed [ENERGY_W-1:0] m_energy_density;
    logic m_saturated;

    longint cfg_dt = 65536;
    longint cfg_inv = 65536;
    longint cfg_df = 0;
    bit clip_hit;

    node_t node_feed[$];
    update_t predicted_updates[$];

    int unsigned src_gap_max = 0;
    int unsigned sink_gap_max = 0;
    int unsigned src_wait = 0;
    int unsigned sink_wait = 0;
    int unsigned hold_left = 0;
    int n_queued = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_clipped = 0;
    int n_errors = 0;
    int n_settings = 1;
    int cycle_count = 0;

    phase_field_node_update #(.PHI_WIDTH(PHI_W)) u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_center_phi     (s_center_phi),
        .s_east_phi       (s_east_phi),
        .s_west_phi       (s_west_phi),
        .s_north_phi      (s_north_phi),
        .s_south_phi      (s_south_phi),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_next_phi       (m_next_phi),
        .m_energy_density (m_energy_density),
        .m_saturated      (m_saturated)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     predicted_updates.size());
            $display("tb: failure");
            $finish;
        end
    end

    function automatic longint lim_clip(longint x);
        if (x > FX_LIM) begin
            clip_hit = 1'b1;
            return FX_LIM;
        end
        if (x < -FX_LIM) begin
            clip_hit = 1'b1;
            return -FX_LIM;
        end
        return x;
    endfunction

    // floor(a*b / 2^16), split so the product never leaves 64 bits
    function automatic longint fx_mul(longint a, longint b);
        longint hi;
        longint lo;
        a = lim_clip(a);
        b = lim_clip(b);
        hi = a >>> FRAC_BITS;
        lo = a - (hi <<< FRAC_BITS);
        return lim_clip(hi * b + ((lo * b) >>> FRAC_BITS));
    endfunction

    function automatic update_t predict_update(node_t nd);
        longint phi, ve, vw, vn, vs;
        longint lap, ph2, omx, gval, gpr, drive, bracket, nxt;
        longint gx, gy, sq, grad, half, ph3, poly, pval, en;
        update_t r;
        phi = nd.c;
        ve = nd.e;
        vw = nd.w;
        vn = nd.n;
        vs = nd.s;
        clip_hit = 1'b0;

        lap = fx_mul(ve + vw + vn + vs - 4 * phi, cfg_inv);
        ph2 = fx_mul(phi, phi);
        omx = FX_ONE - phi;
        gval = fx_mul(ph2, fx_mul(omx, omx));
        gpr = lim_clip(2 * fx_mul(phi, lim_clip(2 * ph2 - 3 * phi + FX_ONE)));
        drive = fx_mul(cfg_df, lim_clip(30 * gval));
        bracket = lim_clip(lap - gpr + drive);
        nxt = phi + fx_mul(cfg_dt, bracket);
        if (nxt > PHI_MAX) begin
            nxt = PHI_MAX;
            clip_hit = 1'b1;
        end
        if (nxt < PHI_MIN) begin
            nxt = PHI_MIN;
            clip_hit = 1'b1;
        end

        gx = ve - vw;
        gy = vn - vs;
        sq = lim_clip(fx_mul(gx, gx) + fx_mul(gy, gy));
        grad = fx_mul(sq, cfg_inv);
        half = grad >>> 3;
        ph3 = fx_mul(ph2, phi);
        poly = lim_clip(6 * ph2 - 15 * phi + 10 * FX_ONE);
        pval = fx_mul(ph3, poly);
        en = lim_clip(half + gval - fx_mul(cfg_df, pval));
        if (en > EN_MAX) begin
            en = EN_MAX;
            clip_hit = 1'b1;
        end
        if (en < EN_MIN) begin
            en = EN_MIN;
            clip_hit = 1'b1;
        end

        r.next_phi = phi_t'(nxt);
        r.energy = ENERGY_W'(en);
        r.sat = clip_hit;
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint wanted);
        if (n_errors < 40) begin
            $display("mismatch at result %0d: %s got %0d, wanted %0d", n_results, field, got,
                     wanted);
        end
        n_errors++;
    endtask

    // source side: one node in flight on the port, next one after a drawn gap
    always @(posedge aclk) begin
        node_t nd;
        node_t cur;
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_wait <= 0;
        end else begin
            if (s_valid && s_ready) begin
                cur = '{s_center_phi, s_east_phi, s_west_phi, s_north_phi, s_south_phi};
                predicted_updates.push_back(predict_update(cur));
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (src_wait > 0) begin
                    src_wait <= src_wait - 1;
                    s_valid <= 1'b0;
                end else if (node_feed.size() > 0) begin
                    nd = node_feed.pop_front();
                    s_center_phi <= nd.c;
                    s_east_phi <= nd.e;
                    s_west_phi <= nd.w;
                    s_north_phi <= nd.n;
                    s_south_phi <= nd.s;
                    s_valid <= 1'b1;
                    src_wait <= (src_gap_max > 0) ? $urandom_range(0, src_gap_max) : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side: compare each transfer, then stall or hold off as drawn
    always @(posedge aclk) begin
        update_t want;
        int unsigned wait_n;
        int unsigned hold_n;
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_wait <= 0;
            hold_left <= 0;
        end else begin
            wait_n = sink_wait;
            hold_n = hold_left;
            if (m_valid && m_ready) begin
                n_results++;
                if (m_saturated) n_clipped++;
                if (predicted_updates.size() == 0) begin
                    report_mismatch("result with nothing pending", m_next_phi, 0);
                end else begin
                    want = predicted_updates.pop_front();
                    if (m_next_phi !== want.next_phi)
                        report_mismatch("next_phi", m_next_phi, want.next_phi);
                    if (m_energy_density !== want.energy)
                        report_mismatch("energy_density", m_energy_density, want.energy);
                    if (m_saturated !== want.sat)
                        report_mismatch("saturated", m_saturated, want.sat);
                end
                wait_n = (sink_gap_max > 0) ? $urandom_range(0, sink_gap_max) : 0;
                if (n_results % HOLD_EVERY == 0) hold_n = HOLD_CYCLES;
            end
            if (hold_n > 0) begin
                m_ready <= 1'b0;
                hold_left <= hold_n - 1;
                sink_wait <= wait_n;
            end else if (wait_n > 0) begin
                m_ready <= 1'b0;
                hold_left <= 0;
                sink_wait <= wait_n - 1;
            end else begin
                m_ready <= 1'b1;
                hold_left <= 0;
                sink_wait <= 0;
            end
        end
    end

    task automatic wait_drained();
        @(posedge aclk);
        while (n_accepted != n_queued || predicted_updates.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
        logic signed [DF_W-1:0] df_bits;
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        df_bits = val[DF_W-1:0];
        case (idx)
            REG_STEP:        cfg_dt = val;
            REG_INV_SPACING: cfg_inv = val;
            REG_DRIVE:       cfg_df = df_bits;
            default: ;
        endcase
    endtask

    task automatic push_node(longint c, longint e, longint w, longint n, longint s);
        node_t nd;
        nd.c = phi_t'(c);
        nd.e = phi_t'(e);
        nd.w = phi_t'(w);
        nd.n = phi_t'(n);
        nd.s = phi_t'(s);
        node_feed.push_back(nd);
        n_queued++;
    endtask

    task automatic push_directed();
        push_node(0, 0, 0, 0, 0);
        push_node(FX_ONE, FX_ONE, FX_ONE, FX_ONE, FX_ONE);
        push_node(PHI_MAX, PHI_MIN, PHI_MIN, PHI_MIN, PHI_MIN);
        push_node(PHI_MIN, PHI_MAX, PHI_MAX, PHI_MAX, PHI_MAX);
        push_node(PHI_MAX, PHI_MAX, PHI_MAX, PHI_MAX, PHI_MAX);
        push_node(PHI_MIN, PHI_MIN, PHI_MIN, PHI_MIN, PHI_MIN);
        push_node(FX_ONE / 2, PHI_MAX, PHI_MIN, PHI_MAX, PHI_MIN);
        push_node(0, PHI_MIN, PHI_MAX, PHI_MIN, PHI_MAX);
        push_node(-1, 1, -1, FX_ONE, -FX_ONE);
        push_node(FX_ONE, 0, 0, 0, 0);
        push_node(PHI_MIN, 0, 0, 0, 0);
        push_node(PHI_MAX, FX_ONE, FX_ONE, FX_ONE, FX_ONE);
    endtask

    function automatic longint rand_field(int unsigned kind, longint base);
        if (kind < 6) return base + longint'($urandom_range(0, 8192)) - 4096;
        if (kind < 9) return longint'(phi_t'($urandom));
        case ($urandom_range(0, 3))
            0: return PHI_MIN;
            1: return PHI_MAX;
            2: return 0;
            default: return FX_ONE;
        endcase
    endfunction

    // mostly smooth interface profiles, some full-range and corner values
    task automatic push_random_node();
        int unsigned kind;
        longint base;
        longint c;
        kind = $urandom_range(0, 9);
        base = longint'($urandom_range(0, 81920)) - 8192;
        c = (kind < 6) ? base : rand_field(kind, base);
        push_node(c, rand_field(kind, base), rand_field(kind, base), rand_field(kind, base),
                  rand_field(kind, base));
    endtask

    function automatic logic [CFG_W-1:0] rand_unsigned_reg();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return CFG_W'($urandom_range(0, 24'h03FFFF));
            default: return CFG_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_drive_reg();
        logic [DF_W-1:0] df;
        case ($urandom_range(0, 3))
            0: df = {1'b1, {(DF_W-1){1'b0}}};
            1: df = {1'b0, {(DF_W-1){1'b1}}};
            2: df = DF_W'(longint'($urandom_range(0, 131072)) - 65536);
            default: df = DF_W'($urandom);
        endcase
        return {3'($urandom_range(0, 7)), df};
    endfunction

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        push_directed();
        wait_drained();

        write_reg(REG_STEP, '1);
        write_reg(REG_INV_SPACING, '1);
        write_reg(REG_DRIVE, {3'b101, 1'b0, {(DF_W-1){1'b1}}});
        n_settings++;
        src_gap_max = 9;
        sink_gap_max = 9;
        push_directed();
        wait_drained();

        for (int r = 0; r < RAND_PHASES; r++) begin
            if (r == 0) begin
                write_reg(REG_STEP, '0);
                write_reg(REG_INV_SPACING, '0);
                write_reg(REG_DRIVE, {3'b010, 1'b1, {(DF_W-1){1'b0}}});
            end else begin
                write_reg(REG_STEP, rand_unsigned_reg());
                write_reg(REG_INV_SPACING, rand_unsigned_reg());
                write_reg(REG_DRIVE, rand_drive_reg());
                if (r == 3) write_reg(REG_UNUSED, CFG_W'($urandom));
            end
            n_settings++;
            src_gap_max = (r % 2 == 0) ? 0 : 9;
            sink_gap_max = (r % 3 == 1) ? 0 : 9;
            repeat (NODES_PER_PHASE) push_random_node();
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("summary: %0d nodes over %0d register settings, %0d updates checked",
                 n_accepted, n_settings, n_results);
        $display("summary: %0d updates clipped, %0d mismatches", n_clipped, n_errors);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: files.f
design/pfn_pkg.sv
design/pfn_qmul.sv
design/phase_field_node_update.sv
test/tb.sv
